### src/qps_pkg.sv
package qps_pkg;

  localparam int POSITION_WIDTH_DEFAULT = 32;
  localparam int MAX_DUTY_DEFAULT = 400;
  localparam int GAIN_DEFAULT = 5;

  localparam int IN_DATA_WIDTH = 8;
  localparam int IN_USER_WIDTH = 2;
  localparam int OUT_DATA_WIDTH = 48;

  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int TOL_WIDTH = 10;
  localparam int PRESET_WIDTH = 16;
  localparam int NUM_PRESETS = 6;
  localparam int MODE_WIDTH = 3;
  localparam int DUTY_PORT_WIDTH = 9;

  localparam logic [1:0] OP_EDGE_A = 2'd0;
  localparam logic [1:0] OP_EDGE_B = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [MODE_WIDTH-1:0] STOP_MODE = 3'd6;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOLERANCE = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRE45 = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLACE45 = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRE25 = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PLACE25 = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PREPLATFORM = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOTTOM = 3'd6;

  localparam logic [TOL_WIDTH-1:0] TOLERANCE_RESET = 10'd20;
  localparam logic signed [PRESET_WIDTH-1:0] PRESET_RESET [NUM_PRESETS] = '{
    -16'sd5300, -16'sd3750, -16'sd4400, -16'sd5375, -16'sd1000, 16'sd0
  };

endpackage

### src/quadrature_position_servo.sv
// Quadrature position servo.
// Input transfers (s_tvalid/s_tready) carry one command each: s_tuser holds
// the operation (edge on A, edge on B, clear position, control tick), s_tdata
// the encoder levels and the target selector. Every input transfer produces
// exactly one result transfer on m_tvalid/m_tready with the position count,
// the drive duty and direction, the active mode and the finished flag.
// The configuration port takes one register write per cycle on cfg_we; it is
// to be written only while no command is in flight.
// The result of a command is registered at the edge that accepts it. The
// throughput is one command per cycle while the receiver takes each result;
// the whole update is done by the logic between the state registers and the
// result register.
// When the receiver stalls, the result register holds its transfer and
// s_tready drops until it is taken; a new command is still accepted in the
// cycle in which the waiting result is taken.
// Reset clears the position and target to zero, stops the drive and loads
// the default tolerance and preset targets; no result is pending after reset.
module quadrature_position_servo #(
  parameter int POSITION_WIDTH = qps_pkg::POSITION_WIDTH_DEFAULT,
  parameter int MAX_DUTY = qps_pkg::MAX_DUTY_DEFAULT,
  parameter int GAIN = qps_pkg::GAIN_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // Fields from bit 0: enc_a, enc_b, target_sel[2:0], zero fill.
  input  logic [qps_pkg::IN_DATA_WIDTH-1:0] s_tdata,
  // Fields from bit 0: op[1:0].
  input  logic [qps_pkg::IN_USER_WIDTH-1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // Fields from bit 0: position[31:0], duty[8:0], clockwise, mode[2:0],
  // finished, zero fill.
  output logic [qps_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
  input  logic cfg_we,
  input  logic [qps_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [qps_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
  import qps_pkg::*;

  localparam int ERR_W = POSITION_WIDTH + 1;
  localparam int DW = $clog2(MAX_DUTY + 1);
  localparam int PW_PROD = DW + 8;

  logic [TOL_WIDTH-1:0] tolerance;
  logic signed [PRESET_WIDTH-1:0] preset [NUM_PRESETS];

  logic signed [POSITION_WIDTH-1:0] position;
  logic signed [PRESET_WIDTH-1:0] target;
  logic [MODE_WIDTH-1:0] mode;
  logic [DW-1:0] duty_level;
  logic clockwise;

  logic signed [POSITION_WIDTH-1:0] position_next;
  logic signed [PRESET_WIDTH-1:0] target_next;
  logic [MODE_WIDTH-1:0] mode_next;
  logic [DW-1:0] duty_next;
  logic clockwise_next;

  logic accept;
  logic [1:0] op;
  logic enc_a;
  logic enc_b;
  logic [2:0] target_sel;
  logic preset_tick;

  logic signed [ERR_W-1:0] err;
  logic err_neg;
  logic [ERR_W-1:0] mag;
  logic on_target;
  logic [PW_PROD-1:0] product;
  logic [DW-1:0] duty_drive;

  logic [POSITION_WIDTH+31:0] position_ext;
  logic [DW+DUTY_PORT_WIDTH-1:0] duty_ext;
  logic finished_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;

  assign op = s_tuser[1:0];
  assign enc_a = s_tdata[0];
  assign enc_b = s_tdata[1];
  assign target_sel = s_tdata[4:2];
  assign preset_tick = (op == OP_TICK) && (target_sel < 3'(NUM_PRESETS));

  always_comb begin
    unique case (op)
      OP_EDGE_A: position_next = (enc_a == enc_b) ? position - POSITION_WIDTH'(1)
                                                  : position + POSITION_WIDTH'(1);
      OP_EDGE_B: position_next = (enc_a == enc_b) ? position + POSITION_WIDTH'(1)
                                                  : position - POSITION_WIDTH'(1);
      OP_CLEAR:  position_next = '0;
      default:   position_next = position;
    endcase
  end

  assign target_next = preset_tick ? preset[target_sel] : target;

  assign err = ERR_W'(target_next) - ERR_W'(position_next);
  assign err_neg = err[ERR_W-1];
  assign mag = err_neg ? ERR_W'(-err) : ERR_W'(err);
  assign on_target = mag <= ERR_W'(tolerance);

  assign product = PW_PROD'(mag[DW-1:0]) * PW_PROD'(GAIN);

  always_comb begin
    if (mag > ERR_W'(MAX_DUTY)) begin
      duty_drive = DW'(MAX_DUTY);
    end else if (product > PW_PROD'(MAX_DUTY)) begin
      duty_drive = DW'(MAX_DUTY);
    end else begin
      duty_drive = product[DW-1:0];
    end
  end

  always_comb begin
    mode_next = mode;
    duty_next = duty_level;
    clockwise_next = clockwise;
    if (op == OP_TICK) begin
      if (preset_tick) begin
        mode_next = target_sel;
        duty_next = on_target ? '0 : duty_drive;
        clockwise_next = on_target ? 1'b0 : err_neg;
      end else if (target_sel == STOP_MODE) begin
        mode_next = STOP_MODE;
        duty_next = '0;
        clockwise_next = 1'b0;
      end
    end
  end

  assign finished_next = on_target;
  assign position_ext = {32'b0, position_next};
  assign duty_ext = {{DUTY_PORT_WIDTH{1'b0}}, duty_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOLERANCE_RESET;
      for (int i = 0; i < NUM_PRESETS; i++) begin
        preset[i] <= PRESET_RESET[i];
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOLERANCE:   tolerance <= cfg_data[TOL_WIDTH-1:0];
        REG_PRE45:       preset[0] <= cfg_data;
        REG_PLACE45:     preset[1] <= cfg_data;
        REG_PRE25:       preset[2] <= cfg_data;
        REG_PLACE25:     preset[3] <= cfg_data;
        REG_PREPLATFORM: preset[4] <= cfg_data;
        REG_BOTTOM:      preset[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      target <= '0;
      mode <= STOP_MODE;
      duty_level <= '0;
      clockwise <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (accept) begin
      position <= position_next;
      target <= target_next;
      mode <= mode_next;
      duty_level <= duty_next;
      clockwise <= clockwise_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b0, finished_next, mode_next, clockwise_next,
                  duty_ext[DUTY_PORT_WIDTH-1:0], position_ext[31:0]};
    end
  end

`ifndef NO_ASSERTIONS
  a_stop_idle: assert property (@(posedge clk) disable iff (rst)
    (mode == STOP_MODE) |-> (duty_level == '0 && !clockwise))
    else $error("Drive active while stopped.");

  a_duty_limit: assert property (@(posedge clk) disable iff (rst)
    duty_level <= DW'(MAX_DUTY))
    else $error("Duty above its limit.");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("Command taken while a result is stalled.");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_CLEAR) |=> (position == '0 && m_tvalid))
    else $error("Clear did not zero the position.");
`endif

endmodule

### test/quadrature_position_servo_tb.sv
module quadrature_position_servo_tb;
  import qps_pkg::*;

  localparam int CLOCK_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;
  localparam int MAX_REPORTS = 40;
  localparam logic [2:0] SEL_IGNORED = 3'd7;

  typedef struct packed {
    logic finished;
    logic [MODE_WIDTH-1:0] mode;
    logic clockwise;
    logic [DUTY_PORT_WIDTH-1:0] duty;
    logic [31:0] position;
  } servo_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_WIDTH-1:0] s_tdata = '0;
  logic [IN_USER_WIDTH-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_WIDTH-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;

  logic signed [31:0] model_pos;
  logic signed [31:0] model_target;
  logic [MODE_WIDTH-1:0] model_mode;
  logic [DUTY_PORT_WIDTH-1:0] model_duty;
  logic model_cw;
  logic [TOL_WIDTH-1:0] model_tol;
  logic signed [PRESET_WIDTH-1:0] model_preset [NUM_PRESETS];

  servo_result_t pending_results [$];
  logic enc_a_level = 1'b0;
  logic enc_b_level = 1'b0;
  bit source_idling = 1'b1;
  bit sink_idling = 1'b1;
  bit hold_request = 1'b0;
  int sink_stall = 0;
  int error_count = 0;
  int commands_sent = 0;
  int results_checked = 0;
  int settings_loaded = 0;
  int cycle_count = 0;

  quadrature_position_servo i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CLOCK_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CLOCK_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint servo_error();
    return longint'(model_target) - longint'(model_pos);
  endfunction

  function automatic longint error_magnitude();
    longint err;
    err = servo_error();
    return (err < 0) ? -err : err;
  endfunction

  task automatic predict_servo_step(logic [1:0] op, logic a, logic b, logic [2:0] sel);
    servo_result_t r;
    longint mag;
    case (op)
      OP_EDGE_A: model_pos = (a == b) ? model_pos - 1 : model_pos + 1;
      OP_EDGE_B: model_pos = (a == b) ? model_pos + 1 : model_pos - 1;
      OP_CLEAR: model_pos = '0;
      default: begin
        if (sel < STOP_MODE) begin
          model_mode = sel;
          model_target = 32'(model_preset[sel]);
          mag = error_magnitude();
          if (mag <= model_tol) begin
            model_duty = '0;
            model_cw = 1'b0;
          end else begin
            if (mag * GAIN_DEFAULT > MAX_DUTY_DEFAULT)
              model_duty = DUTY_PORT_WIDTH'(MAX_DUTY_DEFAULT);
            else model_duty = DUTY_PORT_WIDTH'(mag * GAIN_DEFAULT);
            model_cw = servo_error() < 0;
          end
        end else if (sel == STOP_MODE) begin
          model_mode = STOP_MODE;
          model_duty = '0;
          model_cw = 1'b0;
        end
      end
    endcase
    r.position = model_pos;
    r.duty = model_duty;
    r.clockwise = model_cw;
    r.mode = model_mode;
    r.finished = error_magnitude() <= model_tol;
    pending_results.push_back(r);
  endtask

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      if (error_count < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    servo_result_t got;
    servo_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got = m_tdata[$bits(servo_result_t)-1:0];
      if (pending_results.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("%0t: unexpected result, expected none actual position %0d", $time,
                   $signed(got.position));
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("position", longint'($signed(want.position)),
                      longint'($signed(got.position)));
        compare_field("duty", longint'(want.duty), longint'(got.duty));
        compare_field("clockwise", longint'(want.clockwise), longint'(got.clockwise));
        compare_field("mode", longint'(want.mode), longint'(got.mode));
        compare_field("finished", longint'(want.finished), longint'(got.finished));
        results_checked++;
      end
    end
  end

  // The receiver counts its own stalls; a hold request turns into one long stretch.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      sink_stall = HOLD_CYCLES;
    end
    if (sink_stall > 0) begin
      m_tready <= 1'b0;
      sink_stall--;
    end else if (sink_idling && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      sink_stall = int'($urandom_range(0, 12));
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_command(logic [1:0] op, logic a, logic b, logic [2:0] sel);
    int gap;
    if (source_idling && $urandom_range(0, 4) == 0) begin
      gap = int'($urandom_range(1, 13));
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, sel, b, a};
    s_tuser <= op;
    do @(posedge clk); while (s_tready !== 1'b1);
    predict_servo_step(op, a, b, sel);
    commands_sent++;
    if (op == OP_EDGE_A || op == OP_EDGE_B) begin
      enc_a_level = a;
      enc_b_level = b;
    end
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] index, logic [CFG_DATA_WIDTH-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (index == REG_TOLERANCE) model_tol = value[TOL_WIDTH-1:0];
    else if (index <= REG_BOTTOM) model_preset[index - 1] = value;
  endtask

  task automatic write_presets(logic signed [15:0] p0, logic signed [15:0] p1,
                               logic signed [15:0] p2, logic signed [15:0] p3,
                               logic signed [15:0] p4, logic signed [15:0] p5);
    write_register(REG_PRE45, p0);
    write_register(REG_PLACE45, p1);
    write_register(REG_PRE25, p2);
    write_register(REG_PLACE25, p3);
    write_register(REG_PREPLATFORM, p4);
    write_register(REG_BOTTOM, p5);
    settings_loaded++;
  endtask

  task automatic tick_every_preset();
    int i;
    for (i = 0; i < NUM_PRESETS; i++)
      send_command(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 3'(i));
  endtask

  // A walking step follows the quadrature sequence in the chosen direction.
  task automatic walk_step(bit up);
    logic [2:0] sel;
    sel = 3'($urandom_range(0, 7));
    if (up == (enc_a_level == enc_b_level))
      send_command(OP_EDGE_A, ~enc_a_level, enc_b_level, sel);
    else
      send_command(OP_EDGE_B, enc_a_level, ~enc_b_level, sel);
  endtask

  task automatic run_random_commands(int count);
    int i;
    int r;
    bit up;
    for (i = 0; i < count; i++) begin
      r = int'($urandom_range(0, 99));
      if (r < 72) begin
        if (model_mode != STOP_MODE && $urandom_range(0, 3) != 0) up = model_target > model_pos;
        else up = 1'($urandom_range(0, 1));
        walk_step(up);
      end else if (r < 84) begin
        send_command(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     3'($urandom_range(0, 5)));
      end else if (r < 88) begin
        send_command(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), STOP_MODE);
      end else if (r < 90) begin
        send_command(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     SEL_IGNORED);
      end else if (r < 93) begin
        send_command(OP_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     3'($urandom_range(0, 7)));
      end else begin
        send_command(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      end
    end
  endtask

  task automatic load_random_setting(logic [CFG_DATA_WIDTH-1:0] tol, bit wide);
    logic [15:0] value;
    int i;
    int near;
    wait_for_drain();
    write_register(REG_TOLERANCE, tol);
    for (i = 0; i < NUM_PRESETS; i++) begin
      if (wide) begin
        value = 16'($urandom_range(0, 65535));
      end else begin
        near = int'(model_pos) + int'($urandom_range(0, 300)) - 150;
        if (near > 32767) near = 32767;
        if (near < -32768) near = -32768;
        value = near[15:0];
      end
      write_register(REG_PRE45 + 3'(i), value);
    end
    settings_loaded++;
  endtask

  task automatic test_reset_defaults();
    tick_every_preset();
    send_command(OP_TICK, 1'b0, 1'b0, STOP_MODE);
    send_command(OP_TICK, 1'b1, 1'b1, SEL_IGNORED);
    send_command(OP_EDGE_A, 1'b0, 1'b0, 3'd0);
    send_command(OP_EDGE_A, 1'b1, 1'b0, 3'd7);
    send_command(OP_EDGE_A, 1'b0, 1'b1, 3'd2);
    send_command(OP_EDGE_A, 1'b1, 1'b1, 3'd5);
    send_command(OP_EDGE_B, 1'b0, 1'b0, 3'd1);
    send_command(OP_EDGE_B, 1'b1, 1'b0, 3'd4);
    send_command(OP_EDGE_B, 1'b0, 1'b1, 3'd6);
    send_command(OP_EDGE_B, 1'b1, 1'b1, 3'd3);
    send_command(OP_CLEAR, 1'b1, 1'b0, 3'd7);
  endtask

  // Targets around position zero probe the deadband edge and the duty clamp.
  task automatic test_drive_limits();
    wait_for_drain();
    write_register(REG_TOLERANCE, 16'd3);
    write_presets(16'sd3, -16'sd4, 16'sd80, -16'sd81, -16'sd401, 16'sd32767);
    tick_every_preset();
    wait_for_drain();
    write_register(REG_TOLERANCE, 16'd0);
    write_presets(-16'sd3, 16'sd4, -16'sd80, 16'sd81, 16'sd401, -16'sd32768);
    tick_every_preset();
    wait_for_drain();
    write_register(REG_TOLERANCE, 16'hFFFF);
    send_command(OP_TICK, 1'b0, 1'b1, 3'd5);
    send_command(OP_TICK, 1'b1, 1'b0, 3'd4);
  endtask

  task automatic test_random_settings();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_random_setting(16'd0, 1'b0);
        1: load_random_setting(16'd1023, 1'b0);
        2: load_random_setting(16'($urandom_range(0, 1023)), 1'b1);
        default: load_random_setting(16'($urandom_range(0, 40)), 1'b0);
      endcase
      run_random_commands(130);
    end
  endtask

  task automatic test_backpressure();
    int i;
    load_random_setting(16'($urandom_range(0, 20)), 1'b0);
    source_idling = 1'b0;
    hold_request = 1'b1;
    for (i = 0; i < 40; i++) walk_step(1'($urandom_range(0, 1)));
    source_idling = 1'b1;
    wait_for_drain();
  endtask

  task automatic test_steady_stream();
    load_random_setting(16'($urandom_range(0, 30)), 1'b0);
    source_idling = 1'b0;
    sink_idling = 1'b0;
    run_random_commands(100);
  endtask

  initial begin
    int i;
    model_pos = '0;
    model_target = '0;
    model_mode = STOP_MODE;
    model_duty = '0;
    model_cw = 1'b0;
    model_tol = TOLERANCE_RESET;
    for (i = 0; i < NUM_PRESETS; i++) model_preset[i] = PRESET_RESET[i];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_drive_limits();
    test_random_settings();
    test_backpressure();
    test_steady_stream();
    wait_for_drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d commands and checked %0d results over %0d register settings.",
             commands_sent, results_checked, settings_loaded);
    $display("Quadrature walks, ticks, stops and clears ran with random and long stalls.");
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
